/* rtl/core/oneshot_periodic_timer_table_core_defines.svh */
// Assertion macros for the timer table
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define OPTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("optt: same-cycle check failed");

// next-cycle implication
`define OPTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("optt: next-cycle check failed");

`endif

/* rtl/core/optt_pkg.sv */
package optt_pkg;

  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned TagBitsDef = 8;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FireCntW   = $clog2(MaxResults + 1);

  localparam int unsigned CmdW     = 2;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned TagW     = 8;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned TickW    = 64;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 2'd0,
    CMD_ONESHOT  = 2'd1,
    CMD_PERIODIC = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

endpackage

/* rtl/core/optt_in_if.sv */
interface optt_in_if;
  logic                          valid;
  logic                          ready;
  logic [optt_pkg::CmdW-1:0]     cmd;
  logic [optt_pkg::PeriodW-1:0]  period_ticks;
  logic [optt_pkg::TagW-1:0]     owner_tag;

  modport source (output valid, output cmd, output period_ticks, output owner_tag,
                  input ready);
  modport sink   (input valid, input cmd, input period_ticks, input owner_tag,
                  output ready);
endinterface

/* rtl/core/optt_out_if.sv */
interface optt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic                           ok;
  logic [optt_pkg::SlotIdxW-1:0]  slot_index;
  logic [optt_pkg::TagW-1:0]      fired_tag;
  logic [optt_pkg::TickW-1:0]     now_ticks;
  logic                           last;

  modport source (output valid, output kind, output ok, output slot_index,
                  output fired_tag, output now_ticks, output last, input ready);
  modport sink   (input valid, input kind, input ok, input slot_index,
                  input fired_tag, input now_ticks, input last, output ready);
endinterface

/* rtl/core/oneshot_periodic_timer_table_core.sv */
// Timer table with SLOTS one-shot or periodic slots and a 64-bit tick counter.
// One command is handled at a time; in_i.ready is high only while the block is
// idle. Tick, clear and set commands with a nonzero period each make one
// read-modify-write pass over the slot memory, one slot per cycle through its
// single read and single write port while no fire waits on a stalled output. A
// set command with a zero period skips the pass. Results leave through an output
// register, so the last result of a command may wait there while the next
// command is accepted. A tick emits at most 16 fire transactions; the final
// transaction of every command that emits any carries last.
module oneshot_periodic_timer_table_core #(
  parameter int unsigned SLOTS    = optt_pkg::SlotsDef,
  parameter int unsigned TAG_BITS = optt_pkg::TagBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  optt_in_if.sink    in_i,
  optt_out_if.source out_o
);
  import optt_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [PeriodW-1:0]  period;
    logic [TickW-1:0]    due;
    logic [TAG_BITS-1:0] owner;
    logic                repeats;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  cmd_e                cmd_q, cmd_d;
  logic [PeriodW-1:0]  period_q, period_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [SLOTS-1:0]    live_q, live_d;
  logic [CntW-1:0]     iss_q, iss_d;
  logic                ev_q, ev_d;
  logic [IdxW-1:0]     e_q, e_d;
  logic [FireCntW-1:0] fcnt_q, fcnt_d;
  logic                found_q, found_d;
  logic                ack_q, ack_d;
  logic                ack_ok_q, ack_ok_d;
  logic [IdxW-1:0]     ack_slot_q, ack_slot_d;
  logic                pend_v_q, pend_v_d;
  logic [SlotIdxW-1:0] pend_slot_q, pend_slot_d;
  logic [TagW-1:0]     pend_tag_q, pend_tag_d;

  logic                out_v_q, out_v_d;
  logic                out_kind_q, out_kind_d;
  logic                out_ok_q, out_ok_d;
  logic [SlotIdxW-1:0] out_slot_q, out_slot_d;
  logic [TagW-1:0]     out_tag_q, out_tag_d;
  logic [TickW-1:0]    out_now_q, out_now_d;
  logic                out_last_q, out_last_d;

  slot_t               mem_q [SLOTS];
  slot_t               rdata_q;
  slot_t               wdata;
  logic [IdxW-1:0]     raddr;
  logic                we;

  logic                out_free;
  logic                live_e;
  logic                fire;
  logic                take;
  logic                drop;
  logic                adv;
  logic                issue_more;
  logic [TAG_BITS-1:0] tag_in;
  logic                push;
  logic                push_kind;
  logic                push_ok;
  logic [SlotIdxW-1:0] push_slot;
  logic [TagW-1:0]     push_tag;
  logic                push_last;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_v_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.ok         = out_ok_q;
  assign out_o.slot_index = out_slot_q;
  assign out_o.fired_tag  = out_tag_q;
  assign out_o.now_ticks  = out_now_q;
  assign out_o.last       = out_last_q;

  assign out_free   = !out_v_q || out_o.ready;
  assign tag_in     = TAG_BITS'(in_i.owner_tag);
  assign live_e     = live_q[e_q];
  assign issue_more = (iss_q < CntW'(SLOTS));

  assign fire = (state_q == ST_SCAN) && ev_q && (cmd_q == CMD_TICK) && live_e &&
                (rdata_q.owner != '0) && (tick_q >= rdata_q.due) &&
                (fcnt_q < FireCntW'(MaxResults));
  assign take = (state_q == ST_SCAN) && ev_q && !found_q && !live_e &&
                ((cmd_q == CMD_ONESHOT) || (cmd_q == CMD_PERIODIC));
  assign drop = (state_q == ST_SCAN) && ev_q && (cmd_q == CMD_CLEAR) && live_e &&
                (rdata_q.owner == tag_q);
  assign adv  = !(fire && pend_v_q && !out_free);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    period_d    = period_q;
    tag_d       = tag_q;
    tick_d      = tick_q;
    live_d      = live_q;
    iss_d       = iss_q;
    ev_d        = ev_q;
    e_d         = e_q;
    fcnt_d      = fcnt_q;
    found_d     = found_q;
    ack_d       = ack_q;
    ack_ok_d    = ack_ok_q;
    ack_slot_d  = ack_slot_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_tag_d  = pend_tag_q;
    raddr       = e_q;
    we          = 1'b0;
    wdata       = rdata_q;
    push        = 1'b0;
    push_kind   = 1'b0;
    push_ok     = 1'b1;
    push_slot   = '0;
    push_tag    = '0;
    push_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d      = cmd_e'(in_i.cmd);
          period_d   = in_i.period_ticks;
          tag_d      = tag_in;
          iss_d      = '0;
          ev_d       = 1'b0;
          fcnt_d     = '0;
          found_d    = 1'b0;
          ack_d      = (cmd_e'(in_i.cmd) != CMD_TICK);
          ack_ok_d   = (cmd_e'(in_i.cmd) == CMD_CLEAR) ||
                       ((cmd_e'(in_i.cmd) == CMD_ONESHOT) && (in_i.period_ticks == '0));
          ack_slot_d = '0;
          pend_v_d   = 1'b0;
          state_d    = ST_SCAN;
          if (cmd_e'(in_i.cmd) == CMD_TICK) begin
            tick_d = tick_q + TickW'(1);
          end
          if (((cmd_e'(in_i.cmd) == CMD_ONESHOT) || (cmd_e'(in_i.cmd) == CMD_PERIODIC)) &&
              (in_i.period_ticks == '0)) begin
            state_d     = ST_DONE;
            pend_v_d    = (cmd_e'(in_i.cmd) == CMD_ONESHOT) && (tag_in != '0);
            pend_slot_d = '0;
            pend_tag_d  = TagW'(tag_in);
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          if (fire) begin
            fcnt_d = fcnt_q + FireCntW'(1);
            if (rdata_q.repeats) begin
              we        = 1'b1;
              wdata.due = rdata_q.due + TickW'(rdata_q.period);
            end else begin
              live_d[e_q] = 1'b0;
            end
            if (pend_v_q) begin
              push      = 1'b1;
              push_kind = 1'b1;
              push_slot = pend_slot_q;
              push_tag  = pend_tag_q;
            end
            pend_v_d    = 1'b1;
            pend_slot_d = SlotIdxW'(e_q);
            pend_tag_d  = TagW'(rdata_q.owner);
          end
          if (take) begin
            we            = 1'b1;
            wdata.period  = period_q;
            wdata.due     = tick_q + TickW'(period_q);
            wdata.owner   = tag_q;
            wdata.repeats = (cmd_q == CMD_PERIODIC);
            live_d[e_q]   = 1'b1;
            found_d       = 1'b1;
            ack_ok_d      = 1'b1;
            ack_slot_d    = e_q;
          end
          if (drop) begin
            live_d[e_q] = 1'b0;
          end
          if (issue_more) begin
            raddr = iss_q[IdxW-1:0];
            ev_d  = 1'b1;
            e_d   = iss_q[IdxW-1:0];
            iss_d = iss_q + CntW'(1);
          end else begin
            ev_d    = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (pend_v_q) begin
            push      = 1'b1;
            push_kind = 1'b1;
            push_slot = pend_slot_q;
            push_tag  = pend_tag_q;
            push_last = !ack_q;
            pend_v_d  = 1'b0;
            if (!ack_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            if (ack_q) begin
              push      = 1'b1;
              push_ok   = ack_ok_q;
              push_slot = SlotIdxW'(ack_slot_q);
              push_tag  = TagW'(tag_q);
              push_last = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_kind_d = out_kind_q;
    out_ok_d   = out_ok_q;
    out_slot_d = out_slot_q;
    out_tag_d  = out_tag_q;
    out_now_d  = out_now_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_kind_d = push_kind;
      out_ok_d   = push_ok;
      out_slot_d = push_slot;
      out_tag_d  = push_tag;
      out_now_d  = tick_q;
      out_last_d = push_last;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[e_q] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tick_q   <= '0;
      live_q   <= '0;
      iss_q    <= '0;
      ev_q     <= 1'b0;
      fcnt_q   <= '0;
      found_q  <= 1'b0;
      ack_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      live_q   <= live_d;
      iss_q    <= iss_d;
      ev_q     <= ev_d;
      fcnt_q   <= fcnt_d;
      found_q  <= found_d;
      ack_q    <= ack_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    period_q    <= period_d;
    tag_q       <= tag_d;
    e_q         <= e_d;
    ack_ok_q    <= ack_ok_d;
    ack_slot_q  <= ack_slot_d;
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    out_kind_q  <= out_kind_d;
    out_ok_q    <= out_ok_d;
    out_slot_q  <= out_slot_d;
    out_tag_q   <= out_tag_d;
    out_now_q   <= out_now_d;
    out_last_q  <= out_last_d;
  end

endmodule

/* rtl/core/optt_checker.sv */
`include "oneshot_periodic_timer_table_core_defines.svh"

module optt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_kind_i,
  input logic                          out_ok_i,
  input logic [optt_pkg::SlotIdxW-1:0] out_slot_index_i,
  input logic [optt_pkg::TagW-1:0]     out_fired_tag_i,
  input logic [optt_pkg::TickW-1:0]    out_now_ticks_i,
  input logic                          out_last_i
);

  // stalled transaction keeps its payload
  `OPTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_now_ticks_i) && $stable(out_fired_tag_i) && $stable(out_slot_index_i))

  // one command at a time
  `OPTT_ASSERT_NXT(a_one_cmd, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // an acknowledge always closes its command
  `OPTT_ASSERT_IMP(a_ack_last, clk_i, rst_ni, out_valid_i && !out_kind_i, out_last_i)

  // fires are always ok, refusals point at slot 0
  `OPTT_ASSERT_IMP(a_fire_ok, clk_i, rst_ni, out_valid_i && (out_kind_i || !out_ok_i), out_ok_i || (out_slot_index_i == '0))

endmodule

bind oneshot_periodic_timer_table_core optt_checker u_optt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_ok_i         (out_o.ok),
  .out_slot_index_i (out_o.slot_index),
  .out_fired_tag_i  (out_o.fired_tag),
  .out_now_ticks_i  (out_o.now_ticks),
  .out_last_i       (out_o.last)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic                          kind;
  logic                          ok;
  logic [optt_pkg::SlotIdxW-1:0] slot_index;
  logic [optt_pkg::TagW-1:0]     fired_tag;
  logic [optt_pkg::TickW-1:0]    now_ticks;
  logic                          last;
} timer_result_t;

class timer_table_scoreboard;
  logic [optt_pkg::TickW-1:0]   tick_count;
  logic [optt_pkg::PeriodW-1:0] slot_period [optt_pkg::SlotsDef];
  logic [optt_pkg::TickW-1:0]   slot_due [optt_pkg::SlotsDef];
  logic [optt_pkg::TagW-1:0]    slot_owner [optt_pkg::SlotsDef];
  bit                           slot_repeats [optt_pkg::SlotsDef];
  bit                           slot_live [optt_pkg::SlotsDef];
  timer_result_t                pending_results [$];
  int unsigned                  mismatches;
  int unsigned                  fires_seen;
  int unsigned                  acks_seen;
  int unsigned                  refusals_seen;

  function new();
    tick_count = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    mismatches = 0;
    fires_seen = 0;
    acks_seen = 0;
    refusals_seen = 0;
  endfunction

  function timer_result_t make_result(bit kind, bit ok, int slot,
                                      logic [optt_pkg::TagW-1:0] tag);
    timer_result_t r;
    r.kind = kind;
    r.ok = ok;
    r.slot_index = slot[optt_pkg::SlotIdxW-1:0];
    r.fired_tag = tag;
    r.now_ticks = tick_count;
    r.last = 1'b0;
    return r;
  endfunction

  function int take_slot(logic [optt_pkg::PeriodW-1:0] period,
                         logic [optt_pkg::TagW-1:0] tag, bit repeats);
    for (int i = 0; i < optt_pkg::SlotsDef; i++) begin
      if (!slot_live[i]) begin
        slot_period[i] = period;
        slot_due[i] = tick_count + optt_pkg::TickW'(period);
        slot_owner[i] = tag;
        slot_repeats[i] = repeats;
        slot_live[i] = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  // Works out the result transactions of one accepted command.
  function void note_command(optt_pkg::cmd_e cmd, logic [optt_pkg::PeriodW-1:0] period,
                             logic [optt_pkg::TagW-1:0] raw_tag);
    timer_result_t batch [$];
    logic [optt_pkg::TagW-1:0] tag;
    int s;
    tag = raw_tag & optt_pkg::TagW'((1 << optt_pkg::TagBitsDef) - 1);
    s = -1;
    case (cmd)
      optt_pkg::CMD_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int i = 0; i < optt_pkg::SlotsDef && batch.size() < optt_pkg::MaxResults;
             i++) begin
          if (slot_live[i] && slot_owner[i] != '0 && tick_count >= slot_due[i]) begin
            batch.push_back(make_result(1'b1, 1'b1, i, slot_owner[i]));
            if (slot_repeats[i]) slot_due[i] = slot_due[i] + optt_pkg::TickW'(slot_period[i]);
            else slot_live[i] = 1'b0;
          end
        end
      end
      optt_pkg::CMD_ONESHOT: begin
        if (period == '0) begin
          if (tag != '0) batch.push_back(make_result(1'b1, 1'b1, 0, tag));
          batch.push_back(make_result(1'b0, 1'b1, 0, tag));
        end else begin
          s = take_slot(period, tag, 1'b0);
          batch.push_back(make_result(1'b0, s >= 0, (s >= 0) ? s : 0, tag));
        end
      end
      optt_pkg::CMD_PERIODIC: begin
        if (period != '0) s = take_slot(period, tag, 1'b1);
        batch.push_back(make_result(1'b0, s >= 0, (s >= 0) ? s : 0, tag));
      end
      default: begin
        foreach (slot_live[i])
          if (slot_live[i] && slot_owner[i] == tag) slot_live[i] = 1'b0;
        batch.push_back(make_result(1'b0, 1'b1, 0, tag));
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_results.push_back(batch[k]);
  endfunction

  // Owner tag of a randomly chosen live slot, or -1 if the table is empty.
  function int live_owner();
    int owners [$];
    foreach (slot_live[i])
      if (slot_live[i]) owners.push_back(int'(slot_owner[i]));
    if (owners.size() == 0) return -1;
    return owners[$urandom_range(0, owners.size() - 1)];
  endfunction

  function string format_result(timer_result_t r);
    return $sformatf("kind %0d ok %0d slot %0d tag %02h now %0d last %0d",
                     r.kind, r.ok, r.slot_index, r.fired_tag, r.now_ticks, r.last);
  endfunction

  function void check_result(timer_result_t got);
    timer_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result transaction: %s", $time, format_result(got));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind || got.ok !== want.ok || got.slot_index !== want.slot_index ||
        got.fired_tag !== want.fired_tag || got.now_ticks !== want.now_ticks ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                 format_result(want), format_result(got));
    end
    if (want.kind) fires_seen++;
    else if (want.ok) acks_seen++;
    else refusals_seen++;
  endfunction
endclass

module tb;
  import optt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  optt_in_if  in_if ();
  optt_out_if out_if ();

  oneshot_periodic_timer_table_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  timer_table_scoreboard sb = new();

  int unsigned commands_sent = 0;
  int unsigned burst_left = 0;
  bit          valid_up = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: ready follows a stall pattern that steps through four modes.
  initial begin
    int unsigned rx_cycle;
    timer_result_t got;
    rx_cycle = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.kind = out_if.kind;
        got.ok = out_if.ok;
        got.slot_index = out_if.slot_index;
        got.fired_tag = out_if.fired_tag;
        got.now_ticks = out_if.now_ticks;
        got.last = out_if.last;
        sb.check_result(got);
      end
      case ((rx_cycle / 97) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ((rx_cycle % 7) < 4);
      endcase
      rx_cycle++;
    end
  end

  task automatic lower_valid();
    if (valid_up) begin
      in_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic send_item(cmd_e cmd, logic [PeriodW-1:0] period, logic [TagW-1:0] tag);
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.period_ticks <= period;
    in_if.owner_tag <= tag;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(cmd, period, tag);
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        lower_valid();
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    lower_valid();
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  function automatic logic [TagW-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return TagW'($urandom_range(0, 255));
    return TagW'($urandom_range(1, 16));
  endfunction

  function automatic logic [PeriodW-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 70) return PeriodW'($urandom_range(1, 8));
    if (r < 88) return PeriodW'($urandom_range(9, 64));
    return PeriodW'($urandom);
  endfunction

  task automatic send_random_item();
    int unsigned r;
    int owner;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(CMD_TICK, PeriodW'($urandom), TagW'($urandom));
    end else if (r < 65) begin
      send_item(CMD_ONESHOT, pick_period(), pick_tag());
    end else if (r < 80) begin
      send_item(CMD_PERIODIC, pick_period(), pick_tag());
    end else begin
      owner = sb.live_owner();
      if (owner >= 0 && $urandom_range(0, 3) != 0) send_item(CMD_CLEAR, PeriodW'($urandom),
                                                             TagW'(owner));
      else send_item(CMD_CLEAR, PeriodW'($urandom), pick_tag());
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.period_ticks = '0;
    in_if.owner_tag = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_TICK, '0, '0);
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_ONESHOT, '0, 8'h55);
    send_item(CMD_ONESHOT, '0, '0);
    send_item(CMD_PERIODIC, '0, 8'h07);
    // fill every slot so that one tick fires all of them
    for (int i = 0; i < SlotsDef; i++)
      send_item((i % 2 == 0) ? CMD_ONESHOT : CMD_PERIODIC, 32'd1,
                (i == SlotsDef - 1) ? 8'hFF : TagW'(i + 1));
    send_item(CMD_PERIODIC, 32'd3, 8'h09);
    send_item(CMD_ONESHOT, 32'd3, 8'h09);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_CLEAR, '0, 8'h02);
    send_item(CMD_ONESHOT, 32'hFFFF_FFFF, '0);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, '0);
    wait_all_results();

    for (int n = 0; n < 300; n++) begin
      if (n == 150) wait_all_results();
      send_random_item();
    end

    wait_all_results();
    repeat (2 * SlotsDef + 8) @(posedge clk);
    $display("Ran %0d commands (ticks, one-shot and periodic sets, clears)",
             commands_sent);
    $display("Checked %0d fire, %0d acknowledge and %0d refused transactions, %0d mismatches",
             sb.fires_seen, sb.acks_seen, sb.refusals_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/optt_pkg.sv
rtl/core/optt_in_if.sv
rtl/core/optt_out_if.sv
rtl/core/oneshot_periodic_timer_table_core.sv
rtl/core/optt_checker.sv
sim/tb.sv
